// File: src/i2cmts_pkg.sv
// Shared types and constants for the I2C master transfer sequencer.
// No dependencies; imported by the sequencer top and its stage modules.
`timescale 1ns / 1ps

package i2cmts_pkg;

   // Event codes carried in the mode field
   localparam logic [3:0] MODE_START_READ = 4'd0;
   localparam logic [3:0] MODE_START_SEQ  = 4'd1;
   localparam logic [3:0] MODE_START_ALT  = 4'd2;
   localparam logic [3:0] MODE_TX_SPACE   = 4'd3;
   localparam logic [3:0] MODE_RX_BYTE    = 4'd4;
   localparam logic [3:0] MODE_ABORT      = 4'd5;
   localparam logic [3:0] MODE_OVERRUN    = 4'd6;
   localparam logic [3:0] MODE_STOP       = 4'd7;
   localparam logic [3:0] MODE_RELEASE    = 4'd8;

   // Reported sequencer state
   localparam logic [2:0] STATE_IDLE    = 3'd0;
   localparam logic [2:0] STATE_READING = 3'd1;
   localparam logic [2:0] STATE_WRITING = 3'd2;
   localparam logic [2:0] STATE_DONE    = 3'd3;
   localparam logic [2:0] STATE_ERROR   = 3'd4;

   // Command word flags
   localparam logic [10:0] CMD_READ    = 11'h100;
   localparam logic [10:0] CMD_STOP    = 11'h200;
   localparam logic [10:0] CMD_RESTART = 11'h400;

   // Sticky fault bits
   localparam logic [3:0] FAULT_ABORT   = 4'b0001;
   localparam logic [3:0] FAULT_OVERRUN = 4'b0010;
   localparam logic [3:0] FAULT_EARLY   = 4'b0100;
   localparam logic [3:0] FAULT_STORM   = 4'b1000;

   // Longest transfer; lengths above it are clamped
   localparam logic [16:0] MAX_TRANSFER = 17'd255;

   localparam logic [15:0] STORM_LIMIT_RESET = 16'd10000;
   localparam logic [7:0]  TARGET_NONE       = 8'd255;

   typedef struct packed {
      logic [3:0] mode;
      logic [6:0] dev_addr;
      logic [7:0] length;
      logic [7:0] sub_addr;
      logic [7:0] write_reg;
      logic [7:0] write_data;
      logic [7:0] rx_data;
   } req_item_type;

   typedef struct packed {
      logic        cmd_valid;
      logic [10:0] cmd_word;
      logic [7:0]  item_index;
      logic        byte_valid;
      logic [7:0]  byte_value;
      logic        set_target;
      logic [6:0]  target_value;
      logic [2:0]  state_code;
      logic [3:0]  fault_bits;
      logic        busy_reject;
      logic [7:0]  issued_count;
   } rsp_item_type;

endpackage

// File: src/i2cmts_channels.sv
// Valid/ready channel interfaces for the request and response sides.
// No dependencies.
`timescale 1ns / 1ps

interface i2cmts_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] mode;
   logic [6:0] dev_addr;
   logic [7:0] length;
   logic [7:0] sub_addr;
   logic [7:0] write_reg;
   logic [7:0] write_data;
   logic [7:0] rx_data;

   modport source (
      output valid, mode, dev_addr, length, sub_addr, write_reg, write_data,
             rx_data,
      input  ready
   );
   modport sink (
      input  valid, mode, dev_addr, length, sub_addr, write_reg, write_data,
             rx_data,
      output ready
   );
endinterface

interface i2cmts_rsp_if;
   logic        valid;
   logic        ready;
   logic        cmd_valid;
   logic [10:0] cmd_word;
   logic [7:0]  item_index;
   logic        byte_valid;
   logic [7:0]  byte_value;
   logic        set_target;
   logic [6:0]  target_value;
   logic [2:0]  state_code;
   logic [3:0]  fault_bits;
   logic        busy_reject;
   logic [7:0]  issued_count;

   modport source (
      output valid, cmd_valid, cmd_word, item_index, byte_valid, byte_value,
             set_target, target_value, state_code, fault_bits, busy_reject,
             issued_count,
      input  ready
   );
   modport sink (
      input  valid, cmd_valid, cmd_word, item_index, byte_valid, byte_value,
             set_target, target_value, state_code, fault_bits, busy_reject,
             issued_count,
      output ready
   );
endinterface

// File: src/i2c_master_transfer_sequencer.sv
// I2C master transfer sequencer: event in, one response item out per event.
// Channels: req_if (event item), rsp_if (response item), csr_* storm limit.
// An accepted event lands in the input register; once the result register
// has room it is processed against the sequencer state and written to the
// result register, which offers it on rsp_if. One item enters per cycle
// while rsp_if does not stall; the only loop is the state update, which is
// one step deep.
// Every event returns exactly one response item. A start-read event pushes the
// register byte of a read; tx-space events push one command word each while
// words are left to issue; rx-byte events hand back a requested byte with its index.
// Reset (synchronous, active high) empties both registers, returns the
// sequencer to idle with no target programmed, and sets the storm limit
// to 10000. When rsp_if.ready is low the result is held; the input
// register then takes one more item and req_if.ready drops until the
// result moves. The user must write the storm limit with csr_write_enable
// and csr_write_data only while no event is in flight; the block does not enforce it.
// Depends on i2cmts_pkg, the channel interfaces and the stage modules.
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer
   import i2cmts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   i2cmts_req_if.sink   req_if,
   i2cmts_rsp_if.source rsp_if,
   input  logic         csr_write_enable,
   input  logic [15:0]  csr_write_data
);

   logic         item_valid;
   req_item_type item;
   rsp_item_type result;
   logic         can_load;
   logic         step;

   // advance only when the result register has room
   assign step = item_valid && can_load;

   i2cmts_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .take       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   i2cmts_ctl u_ctl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step             (step),
      .item             (item),
      .result           (result)
   );

   i2cmts_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (step),
      .result   (result),
      .can_load (can_load),
      .rsp_if   (rsp_if)
   );

endmodule

// File: src/i2cmts_in_stage.sv
// Input register of the sequencer: captures one request item.
// Depends on i2cmts_pkg and i2cmts_req_if.
`timescale 1ns / 1ps

module i2cmts_in_stage
   import i2cmts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   i2cmts_req_if.sink   req_if,
   input  logic         take,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         load;

   assign req_if.ready = !valid_ff || take;
   assign load         = req_if.valid && req_if.ready;
   assign valid_in     = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.mode       <= req_if.mode;
         item_ff.dev_addr   <= req_if.dev_addr;
         item_ff.length     <= req_if.length;
         item_ff.sub_addr   <= req_if.sub_addr;
         item_ff.write_reg  <= req_if.write_reg;
         item_ff.write_data <= req_if.write_data;
         item_ff.rx_data    <= req_if.rx_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: src/i2cmts_ctl.sv
// Sequencer state and next-result logic; one item is handled per step.
// Depends on i2cmts_pkg.
`timescale 1ns / 1ps

module i2cmts_ctl
   import i2cmts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [15:0]  csr_write_data,
   input  logic         step,
   input  req_item_type item,
   output rsp_item_type result
);

   typedef enum logic [2:0] {
      ST_IDLE    = STATE_IDLE,
      ST_READING = STATE_READING,
      ST_WRITING = STATE_WRITING,
      ST_DONE    = STATE_DONE,
      ST_ERROR   = STATE_ERROR
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  last_target_ff, last_target_in;
   logic        write_kind_ff, write_kind_in;
   logic        write_phase_ff, write_phase_in;
   logic [7:0]  issued_ff, issued_in;
   logic [7:0]  received_ff, received_in;
   logic [7:0]  xfer_length_ff, xfer_length_in;
   logic [3:0]  faults_ff, faults_in;
   logic [15:0] event_hits_ff, event_hits_in;
   logic [15:0] storm_limit_ff;

   logic        active;
   logic        last_item;
   logic [15:0] hits_next;
   logic [7:0]  clamped_length;

   assign active    = (state_ff == ST_READING) || (state_ff == ST_WRITING);
   assign last_item = ({1'b0, issued_ff} + 9'd1) == {1'b0, xfer_length_ff};
   assign hits_next = (event_hits_ff == 16'hFFFF) ? event_hits_ff : event_hits_ff + 16'd1;
   assign clamped_length = ({9'd0, item.length} > MAX_TRANSFER) ? MAX_TRANSFER[7:0]
                                                               : item.length;

   always_comb begin
      result         = '0;
      state_in       = state_ff;
      last_target_in = last_target_ff;
      write_kind_in  = write_kind_ff;
      write_phase_in = write_phase_ff;
      issued_in      = issued_ff;
      received_in    = received_ff;
      xfer_length_in = xfer_length_ff;
      faults_in      = faults_ff;
      event_hits_in  = event_hits_ff;

      if (item.mode <= MODE_START_ALT) begin
         if (state_ff != ST_IDLE) begin
            result.busy_reject = 1'b1;
         end else begin
            if ({1'b0, item.dev_addr} != last_target_ff) begin
               result.set_target   = 1'b1;
               result.target_value = item.dev_addr;
               last_target_in      = {1'b0, item.dev_addr};
            end
            xfer_length_in = clamped_length;
            issued_in      = '0;
            received_in    = '0;
            faults_in      = '0;
            event_hits_in  = '0;
            write_phase_in = 1'b0;
            if (item.mode == MODE_START_READ) begin
               write_kind_in    = 1'b0;
               result.cmd_valid = 1'b1;
               result.cmd_word  = {3'b000, item.sub_addr};
               state_in         = ST_READING;
            end else begin
               write_kind_in = (item.mode == MODE_START_ALT);
               state_in      = ST_WRITING;
            end
         end
      end else if (item.mode <= MODE_STOP) begin
         event_hits_in = hits_next;
         if (hits_next > storm_limit_ff) begin
            faults_in = faults_ff | FAULT_STORM;
            state_in  = ST_ERROR;
         end else begin
            case (item.mode)
               MODE_TX_SPACE: begin
                  if (issued_ff < xfer_length_ff) begin
                     if (state_ff == ST_READING) begin
                        result.cmd_word = CMD_READ
                                        | ((issued_ff == 8'd0) ? CMD_RESTART : 11'd0)
                                        | (last_item ? CMD_STOP : 11'd0);
                        result.cmd_valid  = 1'b1;
                        result.item_index = issued_ff;
                        issued_in         = issued_ff + 8'd1;
                     end else if (state_ff == ST_WRITING) begin
                        result.cmd_valid  = 1'b1;
                        result.item_index = issued_ff;
                        if (!write_kind_ff) begin
                           result.cmd_word = {3'b000, item.write_reg}
                                           | (last_item ? CMD_STOP : 11'd0);
                           issued_in = issued_ff + 8'd1;
                        end else if (!write_phase_ff) begin
                           // register byte first, data byte on the next event
                           result.cmd_word = {3'b000, item.write_reg};
                           write_phase_in  = 1'b1;
                        end else begin
                           result.cmd_word = {3'b000, item.write_data}
                                           | (last_item ? CMD_STOP : 11'd0);
                           write_phase_in  = 1'b0;
                           issued_in       = issued_ff + 8'd1;
                        end
                     end
                  end
               end
               MODE_RX_BYTE: begin
                  // drop bytes that were never asked for
                  if (state_ff == ST_READING && received_ff < issued_ff) begin
                     result.byte_valid = 1'b1;
                     result.byte_value = item.rx_data;
                     result.item_index = received_ff;
                     received_in       = received_ff + 8'd1;
                  end
               end
               MODE_ABORT: begin
                  if (active) begin
                     faults_in = faults_ff | FAULT_ABORT;
                     state_in  = ST_ERROR;
                  end
               end
               MODE_OVERRUN: begin
                  if (state_ff == ST_READING) begin
                     faults_in = faults_ff | FAULT_OVERRUN;
                     state_in  = ST_ERROR;
                  end
               end
               MODE_STOP: begin
                  if (active) begin
                     if ((state_ff == ST_READING && received_ff == xfer_length_ff) ||
                         (state_ff == ST_WRITING && issued_ff == xfer_length_ff)) begin
                        state_in = ST_DONE;
                     end else begin
                        faults_in = faults_ff | FAULT_EARLY;
                        state_in  = ST_ERROR;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end else if (item.mode == MODE_RELEASE) begin
         if (active) begin
            result.busy_reject = 1'b1;
         end else begin
            state_in = ST_IDLE;
         end
      end

      result.state_code   = state_in;
      result.fault_bits   = faults_in;
      result.issued_count = issued_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         last_target_ff <= TARGET_NONE;
         write_kind_ff  <= 1'b0;
         write_phase_ff <= 1'b0;
         issued_ff      <= '0;
         received_ff    <= '0;
         xfer_length_ff <= '0;
         faults_ff      <= '0;
         event_hits_ff  <= '0;
      end else if (step) begin
         state_ff       <= state_in;
         last_target_ff <= last_target_in;
         write_kind_ff  <= write_kind_in;
         write_phase_ff <= write_phase_in;
         issued_ff      <= issued_in;
         received_ff    <= received_in;
         xfer_length_ff <= xfer_length_in;
         faults_ff      <= faults_in;
         event_hits_ff  <= event_hits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         storm_limit_ff <= STORM_LIMIT_RESET;
      end else if (csr_write_enable) begin
         storm_limit_ff <= csr_write_data;
      end
   end

endmodule

// File: src/i2cmts_out_stage.sv
// Result register of the sequencer: holds one response item until taken.
// Depends on i2cmts_pkg and i2cmts_rsp_if.
`timescale 1ns / 1ps

module i2cmts_out_stage
   import i2cmts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  rsp_item_type  result,
   output logic          can_load,
   i2cmts_rsp_if.source  rsp_if
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign can_load = !valid_ff || rsp_if.ready;
   assign valid_in = load || (valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.cmd_valid    = item_ff.cmd_valid;
   assign rsp_if.cmd_word     = item_ff.cmd_word;
   assign rsp_if.item_index   = item_ff.item_index;
   assign rsp_if.byte_valid   = item_ff.byte_valid;
   assign rsp_if.byte_value   = item_ff.byte_value;
   assign rsp_if.set_target   = item_ff.set_target;
   assign rsp_if.target_value = item_ff.target_value;
   assign rsp_if.state_code   = item_ff.state_code;
   assign rsp_if.fault_bits   = item_ff.fault_bits;
   assign rsp_if.busy_reject  = item_ff.busy_reject;
   assign rsp_if.issued_count = item_ff.issued_count;

endmodule

// File: src/i2cmts_checker.sv
// Port-level checks for the I2C master transfer sequencer, bound to the top.
// Depends on the top level's response port.
`timescale 1ns / 1ps

module i2cmts_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        cmd_valid,
   input logic [10:0] cmd_word,
   input logic        byte_valid,
   input logic [7:0]  byte_value,
   input logic        set_target,
   input logic        busy_reject
);

   // a stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(cmd_word) && $stable(byte_value))
      else $error("response item changed while stalled");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(cmd_valid && byte_valid))
      else $error("command and received byte in one item");

   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && busy_reject |-> !cmd_valid && !byte_valid && !set_target)
      else $error("refused request still produced output");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (cmd_valid || cmd_word == 11'd0) && (byte_valid || byte_value == 8'd0))
      else $error("payload not cleared without its valid flag");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind i2c_master_transfer_sequencer i2cmts_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .cmd_valid   (rsp_if.cmd_valid),
   .cmd_word    (rsp_if.cmd_word),
   .byte_valid  (rsp_if.byte_valid),
   .byte_value  (rsp_if.byte_value),
   .set_target  (rsp_if.set_target),
   .busy_reject (rsp_if.busy_reject)
);
